// ===== rtl/modexp_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the modular exponentiation block.
package modexp_pkg;

    localparam int unsigned BaseW       = 63;
    localparam int unsigned ExpW        = 63;
    localparam int unsigned OutW        = 30;
    localparam int unsigned ModW        = 30;
    localparam int unsigned ExpBitsDflt = 63;

    localparam logic [63:0] PrimeMod64 = 64'd1000000007;
    localparam logic [ModW-1:0] PrimeMod = PrimeMod64[ModW-1:0];
    localparam logic [63:0] TwoPrime64 = PrimeMod64 * 64'd2;
    localparam logic [31:0] TwoPrime = TwoPrime64[31:0];

    // Barrett constant floor(2^60 / P) and the fold constant 2^30 mod P.
    localparam logic [63:0] BarrettMu64 = (64'd1 << 60) / PrimeMod64;
    localparam logic [30:0] BarrettMu = BarrettMu64[30:0];
    localparam logic [63:0] Fold64 = (64'd1 << 30) % PrimeMod64;
    localparam logic [ModW-1:0] FoldConst = Fold64[ModW-1:0];

    typedef enum logic {
        MM_DEST_BASE = 1'b0,
        MM_DEST_ACC  = 1'b1
    } t_mm_dest;

    typedef struct packed {
        logic            valid;
        t_mm_dest        dest;
        logic [ModW-1:0] a;
        logic [ModW-1:0] b;
        logic [ModW-1:0] c;
    } t_mm_req;

    typedef struct packed {
        logic            valid;
        t_mm_dest        dest;
        logic [ModW-1:0] value;
    } t_mm_rsp;

endpackage

// ===== rtl/modexp_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the operand and result beats.
interface modexp_in_if;
    logic        valid;
    logic        ready;
    logic [62:0] base_value;
    logic [62:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink (input valid, input base_value, input exponent, output ready);
endinterface

interface modexp_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink (input valid, input power_mod, output ready);
endinterface

// ===== rtl/modexp_mulmod.sv =====
`timescale 1ns / 1ps
// Four-stage pipelined unit computing (a * b + c) mod P with Barrett reduction.
module modexp_mulmod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  modexp_pkg::t_mm_req i_req,
    output modexp_pkg::t_mm_rsp o_rsp,
    output logic               o_busy
);
    import modexp_pkg::*;

    logic            r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    t_mm_dest        r_s1_dest, r_s2_dest, r_s3_dest, r_s4_dest;
    logic [59:0]     r_s1_x;
    logic [61:0]     r_s2_t;
    logic [31:0]     r_s2_x;
    logic [31:0]     r_s3_r;
    logic [ModW-1:0] r_s4_val;

    logic [60:0]     w_qp;
    logic [32:0]     w_sub1;
    logic [32:0]     w_sub2;
    logic [ModW-1:0] w_red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_req.valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    // The quotient estimate is at most two low, so the remainder stays below 3P.
    assign w_qp   = 61'(r_s2_t[61:31]) * 61'(PrimeMod);
    assign w_sub1 = {1'b0, r_s3_r} - 33'(PrimeMod);
    assign w_sub2 = {1'b0, r_s3_r} - 33'(TwoPrime);

    always_comb begin
        priority if (!w_sub2[32]) begin
            w_red = w_sub2[ModW-1:0];
        end else if (!w_sub1[32]) begin
            w_red = w_sub1[ModW-1:0];
        end else begin
            w_red = r_s3_r[ModW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dest <= i_req.dest;
        r_s1_x    <= 60'(i_req.a) * 60'(i_req.b) + 60'(i_req.c);
        r_s2_dest <= r_s1_dest;
        r_s2_t    <= 62'(r_s1_x[59:29]) * 62'(BarrettMu);
        r_s2_x    <= r_s1_x[31:0];
        r_s3_dest <= r_s2_dest;
        r_s3_r    <= r_s2_x - w_qp[31:0];
        r_s4_dest <= r_s3_dest;
        r_s4_val  <= w_red;
    end

    assign o_rsp.valid = r_s4_vld;
    assign o_rsp.dest  = r_s4_dest;
    assign o_rsp.value = r_s4_val;
    assign o_busy      = r_s1_vld | r_s2_vld | r_s3_vld | r_s4_vld;

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> ({1'b0, r_s3_r} < 33'(TwoPrime) + 33'(PrimeMod)))
        else $error("Barrett remainder out of range");

    a_rsp_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld |-> (r_s4_val < PrimeMod))
        else $error("mulmod result not reduced");

    a_pipe_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |=> r_s4_vld)
        else $error("mulmod pipeline dropped a beat");
`endif

endmodule

// ===== rtl/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// Top level: base^exponent mod 1000000007 by right-to-left square and multiply.
//
// Usage: an operand beat (base_value, exponent) is taken on i_in when valid
// and ready are both high; one result beat (power_mod) leaves on o_out.
// i_in.ready is high only while the block is idle, so one item is worked at
// a time. All arithmetic runs through a single pipelined multiply-reduce
// unit. The base is first folded below the prime in two unit passes. Each
// exponent bit then costs a squaring, plus a multiply into the accumulator
// when the bit is set. Scanning stops once the remaining exponent bits are
// all zero. The block returns to idle, ready for the next operand beat, as
// the result is loaded into the output register.
// Results sit in an output register; a new item is accepted while a result
// waits there, and the block stalls at its end only if that register is
// still full. Synchronous active-low reset returns to idle with no result
// pending.
module modular_exponentiation #(
    parameter int unsigned EXP_BITS = modexp_pkg::ExpBitsDflt
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    modexp_in_if.sink    i_in,
    modexp_out_if.source o_out
);
    import modexp_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_RED_HI   = 9'b000000010,
        ST_RED_HI_W = 9'b000000100,
        ST_RED_LO   = 9'b000001000,
        ST_RED_LO_W = 9'b000010000,
        ST_BIT      = 9'b000100000,
        ST_MUL      = 9'b001000000,
        ST_BIT_W    = 9'b010000000,
        ST_DONE     = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [ModW-1:0]     r_b;
    logic [ModW-1:0]     r_acc;
    logic [ModW-1:0]     r_base_mid;
    logic [ModW-1:0]     r_base_lo;
    logic [EXP_BITS-1:0] r_exp;
    logic                r_out_vld;
    logic [OutW-1:0]     r_out_val;

    t_mm_req w_req;
    t_mm_rsp w_rsp;
    logic    w_busy;
    logic    w_in_fire;
    logic    w_out_free;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_vld || o_out.ready;

    always_comb begin
        n_state     = r_state;
        w_req.valid = 1'b0;
        w_req.dest  = MM_DEST_BASE;
        w_req.a     = r_b;
        w_req.b     = r_b;
        w_req.c     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) n_state = ST_RED_HI;
            end
            // Horner fold of the 63-bit base: r = r * 2^30 + next 30-bit chunk, mod P.
            ST_RED_HI: begin
                w_req.valid = 1'b1;
                w_req.b     = FoldConst;
                w_req.c     = r_base_mid;
                n_state     = ST_RED_HI_W;
            end
            ST_RED_HI_W: begin
                if (!w_busy) n_state = ST_RED_LO;
            end
            ST_RED_LO: begin
                w_req.valid = 1'b1;
                w_req.b     = FoldConst;
                w_req.c     = r_base_lo;
                n_state     = ST_RED_LO_W;
            end
            ST_RED_LO_W: begin
                if (!w_busy) n_state = ST_BIT;
            end
            ST_BIT: begin
                if (r_exp == '0) begin
                    n_state = ST_DONE;
                end else begin
                    w_req.valid = 1'b1;
                    n_state     = ST_MUL;
                end
            end
            // The multiply reads the old square, since the new one is still in flight.
            ST_MUL: begin
                w_req.valid = r_exp[0];
                w_req.dest  = MM_DEST_ACC;
                w_req.a     = r_acc;
                n_state     = ST_BIT_W;
            end
            ST_BIT_W: begin
                if (!w_busy) n_state = ST_BIT;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    modexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp),
        .o_busy  (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_b        <= ModW'(i_in.base_value[62:60]);
            r_base_mid <= i_in.base_value[59:30];
            r_base_lo  <= i_in.base_value[29:0];
            r_acc      <= ModW'(1);
            r_exp      <= i_in.exponent[EXP_BITS-1:0];
        end else begin
            if (w_rsp.valid) begin
                unique case (w_rsp.dest)
                    MM_DEST_BASE: r_b   <= w_rsp.value;
                    MM_DEST_ACC:  r_acc <= w_rsp.value;
                    default:      r_b   <= w_rsp.value;
                endcase
            end
            if (r_state == ST_MUL) r_exp <= r_exp >> 1;
        end
        if (r_state == ST_DONE && w_out_free) r_out_val <= r_acc;
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.power_mod = r_out_val;

`ifndef SYNTHESIS
    a_rsp_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.valid |-> (r_state == ST_RED_HI_W || r_state == ST_RED_LO_W ||
                         r_state == ST_BIT_W))
        else $error("mulmod result arrived outside a wait state");

    a_operands_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BIT) |-> (r_acc < PrimeMod && r_b < PrimeMod))
        else $error("square or accumulator not reduced");

    a_issue_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.valid |-> (!w_busy || r_state == ST_MUL))
        else $error("mulmod issued while an earlier step is unfinished");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> (o_out.valid && r_state == ST_IDLE))
        else $error("finished item did not reach the output register");
`endif

endmodule

// ===== verif/modular_exponentiation_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the modular exponentiation block.
module modular_exponentiation_tb;
    import modexp_pkg::*;

    localparam int ResetCycles = 6;
    localparam int RandomItems = 800;
    localparam int DrainEvery  = 250;
    localparam int TailCycles  = 500;
    localparam int CycleLimit  = 2_000_000;

    localparam logic [BaseW-1:0] FieldMax = {BaseW{1'b1}};

    typedef struct {
        logic [BaseW-1:0] base_value;
        logic [ExpW-1:0]  exponent;
    } t_operand;

    logic i_clk;
    logic i_rst_n;

    modexp_in_if  operand_if ();
    modexp_out_if result_if ();

    modular_exponentiation u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (operand_if),
        .o_out   (result_if)
    );

    t_operand         operand_q[$];
    logic [OutW-1:0]  power_mod_q[$];
    int               error_count = 0;
    int               sent_count = 0;
    int               recv_count = 0;
    int               send_gap = 0;
    int               recv_stall = 0;
    longint           cycle_count = 0;

    // Right-to-left square and multiply over every exponent bit.
    function automatic logic [OutW-1:0] predict_power_mod(logic [BaseW-1:0] base_in,
                                                          logic [ExpW-1:0] exp_in);
        logic [63:0] square;
        logic [63:0] acc;
        square = {1'b0, base_in} % PrimeMod64;
        acc    = 64'd1;
        for (int k = 0; k < ExpW; k++) begin
            if (exp_in[k]) begin
                acc = (acc * square) % PrimeMod64;
            end
            square = (square * square) % PrimeMod64;
        end
        return acc[OutW-1:0];
    endfunction

    function automatic logic [62:0] rand_word63();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[62:0];
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len(int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) begin
            return 0;
        end else if (r < 97) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [BaseW-1:0] rand_base();
        logic [63:0] multiple;
        case ($urandom_range(0, 5))
            0, 1: return rand_word63();
            2: return BaseW'($urandom_range(0, 3));
            3: begin
                // Land on or right next to a multiple of the prime.
                multiple = 64'($urandom) * PrimeMod64 + 64'($urandom_range(0, 2)) - 64'd1;
                return multiple[BaseW-1:0];
            end
            4: return FieldMax - BaseW'($urandom_range(0, 1000));
            default: return BaseW'($urandom_range(0, 1000000006));
        endcase
    endfunction

    function automatic logic [ExpW-1:0] rand_exponent();
        logic [ExpW-1:0] value;
        int              width;
        width = $urandom_range(0, ExpW);
        value = rand_word63();
        if (width == 0) begin
            value = '0;
        end else begin
            if (width < ExpW) begin
                value = value & ((ExpW'(1) << width) - ExpW'(1));
            end
            if ($urandom_range(0, 1) == 1) begin
                value[width-1] = 1'b1;
            end
        end
        return value;
    endfunction

    task automatic add_operand(logic [BaseW-1:0] base_in, logic [ExpW-1:0] exp_in);
        t_operand item;
        item.base_value = base_in;
        item.exponent   = exp_in;
        operand_q.insert(operand_q.size(), item);
    endtask

    task automatic expect_result(logic [OutW-1:0] value);
        power_mod_q.insert(power_mod_q.size(), value);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Driver: one operand beat at a time from the pending queue.
    always @(posedge i_clk) begin
        t_operand cur;
        if (!i_rst_n) begin
            operand_if.valid      <= 1'b0;
            operand_if.base_value <= '0;
            operand_if.exponent   <= '0;
            send_gap = 0;
        end else begin
            if (operand_if.valid && operand_if.ready) begin
                expect_result(predict_power_mod(operand_if.base_value,
                                                operand_if.exponent));
                sent_count++;
            end
            if (!operand_if.valid || operand_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    operand_if.valid <= 1'b0;
                end else if ((sent_count % DrainEvery) == DrainEvery - 1
                             && power_mod_q.size() != 0) begin
                    // Hold off until the block has delivered everything.
                    operand_if.valid <= 1'b0;
                end else if (operand_q.size() != 0) begin
                    cur = operand_q.pop_front();
                    operand_if.valid      <= 1'b1;
                    operand_if.base_value <= cur.base_value;
                    operand_if.exponent   <= cur.exponent;
                    send_gap = ((sent_count / 100) % 3 == 1) ? 0 : idle_len(50);
                end else begin
                    operand_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        logic [OutW-1:0] want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                recv_count++;
                if (power_mod_q.size() == 0) begin
                    $error("power_mod: no result expected, actual %0d", result_if.power_mod);
                    error_count++;
                end else begin
                    want = power_mod_q.pop_front();
                    if (result_if.power_mod !== want) begin
                        $error("power_mod: expected %0d, actual %0d", want,
                               result_if.power_mod);
                        error_count++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
                recv_stall = ((recv_count / 40) % 3 == 1) ? 0 : idle_len(70);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        // Directed corners: zero exponent, multiples of the prime, field extremes.
        add_operand('0, '0);
        add_operand(FieldMax, '0);
        add_operand('0, ExpW'(1));
        add_operand('0, FieldMax);
        add_operand(BaseW'(1), FieldMax);
        add_operand(BaseW'(PrimeMod64), ExpW'(1));
        add_operand(BaseW'(PrimeMod64 * 64'd2), ExpW'(12345));
        add_operand(BaseW'(PrimeMod64 - 64'd1), ExpW'(2));
        add_operand(BaseW'(PrimeMod64 - 64'd1), ExpW'(3));
        add_operand(BaseW'(PrimeMod64 + 64'd1), FieldMax);
        add_operand(FieldMax, FieldMax);
        add_operand(FieldMax, ExpW'(1));
        add_operand(BaseW'(2), ExpW'(1) << (ExpW - 1));
        add_operand(BaseW'(3), ExpW'(PrimeMod64 - 64'd1));
        add_operand(BaseW'(123456789), ExpW'(PrimeMod64 - 64'd2));
        add_operand(BaseW'(2), ExpW'(30));
        add_operand(rand_word63(), rand_word63());
        for (int n = 0; n < RandomItems; n++) begin
            add_operand(rand_base(), rand_exponent());
        end

        do begin
            @(negedge i_clk);
        end while (!i_rst_n || operand_q.size() != 0 || operand_if.valid
                   || power_mod_q.size() != 0);
        repeat (TailCycles) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/modexp_pkg.sv
rtl/modexp_if.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation.sv
verif/modular_exponentiation_tb.sv
